// File: hdl/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise-linear table inverse core.
// ----------------------------------------------------------------------------
package plti_pkg;

   // default table depth
   localparam int TABLE_DEPTH_DEF = 64;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int SIZE_W   = 7;
   localparam int MAPPED_W = 24;
   localparam int FRAC_W   = 16;
   localparam int SEG_W    = 8;   // segment number, enough for the largest depth
   localparam int CNT_W    = 9;   // holds a depth up to 256

   // request kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_ZERO_DIV  = 2'd2
   } status_type;

   // search result handed to the divider preparation stage
   typedef struct packed {
      logic               valid;
      logic               eof;
      logic               found;
      logic               below;
      logic [SEG_W-1:0]   seg;
      logic [VALUE_W-1:0] smp;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
   } search_type;

   // sideband carried along the divider
   typedef struct packed {
      logic                valid;
      logic                eof;
      status_type          status;
      logic [MAPPED_W-1:0] base;
   } side_type;

endpackage

// File: hdl/piecewise_linear_table_inverse_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_inverse_core
// Maps Q16.16 samples to Q8.16 segment positions of a breakpoint table.
// ----------------------------------------------------------------------------
// One sample request is taken every cycle while the result side keeps up;
// a sample passes three search stages (compare, group priority, group
// select with breakpoint read), one operand stage, 17 divider stages and the
// output register. Load requests write the table and give no result; one is
// taken only once no sample is in flight, so a load behind samples waits
// until the pipeline has drained.
module piecewise_linear_table_inverse_core
   import plti_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // csr
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data,      // table_size
   // request
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [71:0]         req_tdata,        // entry_index, entry_value, sample
   input  logic                req_tuser,        // kind
   input  logic                req_tlast,        // end_of_frame
   // response
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [MAPPED_W-1:0] rsp_tdata,        // mapped_value
   output logic [1:0]          rsp_tuser,        // status
   output logic                rsp_tlast         // last_out
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [SIZE_W-1:0] size_ff;

   // table size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // effective size and searched segment count
   logic [CNT_W-1:0] eff_size;
   logic [CNT_W-1:0] searched;

   always_comb begin
      eff_size = (CNT_W'(size_ff) < CNT_W'(TABLE_DEPTH)) ? CNT_W'(size_ff)
                                                         : CNT_W'(TABLE_DEPTH);
      searched = (eff_size > CNT_W'(2)) ? eff_size - CNT_W'(2) : '0;
   end

   // handshake
   logic       advance;
   logic       busy_all;
   logic       search_busy;
   logic       div_busy;
   logic       s4_valid_ff;
   logic       out_valid_ff;
   logic       req_fire;
   logic [INDEX_W-1:0] entry_index;

   assign advance     = !out_valid_ff || rsp_tready;
   assign busy_all    = search_busy | s4_valid_ff | div_busy | out_valid_ff;
   assign req_tready  = advance && (req_tuser == KIND_SAMPLE || !busy_all);
   assign req_fire    = req_tvalid && req_tready;
   assign entry_index = req_tdata[INDEX_W-1:0];

   search_type res;

   plti_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .wr_en     (req_fire && req_tuser == KIND_LOAD &&
                  CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH)),
      .wr_addr   (AW'(entry_index)),
      .wr_data   (req_tdata[37:6]),
      .in_valid  (req_fire && req_tuser == KIND_SAMPLE),
      .in_sample (req_tdata[69:38]),
      .in_eof    (req_tlast),
      .searched  (searched),
      .busy      (search_busy),
      .result    (res)
   );

   // operand stage: numerator, divisor, integer part and status
   logic [VALUE_W-1:0] num_in;
   logic [VALUE_W-1:0] den_in;
   side_type           side_in;

   always_comb begin
      if (res.below) begin
         num_in       = res.smp;
         den_in       = res.lo;
         side_in.base = '0;
      end else begin
         num_in       = res.smp - res.lo;
         den_in       = res.hi - res.lo;
         side_in.base = MAPPED_W'(res.seg + SEG_W'(1)) << FRAC_W;
      end
      side_in.valid = res.valid;
      side_in.eof   = res.eof;
      if (!res.found) begin
         side_in.status = STATUS_NOT_FOUND;
      end else if (den_in == '0) begin
         side_in.status = STATUS_ZERO_DIV;
      end else begin
         side_in.status = STATUS_OK;
      end
   end

   logic [VALUE_W-1:0] s4_num_ff;
   logic [VALUE_W-1:0] s4_den_ff;
   side_type           s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_num_ff  <= num_in;
         s4_den_ff  <= den_in;
         s4_side_ff <= side_in;
      end
   end

   side_type            side_s4;
   side_type            div_side;
   logic [FRAC_W-1:0]   div_quot;

   always_comb begin
      side_s4       = s4_side_ff;
      side_s4.valid = s4_valid_ff;
   end

   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .num      (s4_num_ff),
      .den      (s4_den_ff),
      .side_in  (side_s4),
      .busy     (div_busy),
      .quot     (div_quot),
      .side_out (div_side)
   );

   // output register
   logic [MAPPED_W-1:0] out_value_ff;
   logic [1:0]          out_status_ff;
   logic                out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff  <= (div_side.status == STATUS_OK)
                          ? (div_side.base | MAPPED_W'(div_quot)) : '0;
         out_status_ff <= div_side.status;
         out_last_ff   <= div_side.eof;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hdl/plti_search.sv
// ----------------------------------------------------------------------------
// plti_search
// Breakpoint table, parallel compares, two-level first-match search and
// registered read of the two bounding breakpoints.
// ----------------------------------------------------------------------------
module plti_search
   import plti_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [VALUE_W-1:0]             wr_data,
   input  logic                           in_valid,
   input  logic [VALUE_W-1:0]             in_sample,
   input  logic                           in_eof,
   input  logic [CNT_W-1:0]               searched,
   output logic                           busy,
   output search_type                     result
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int GS = 16;
   localparam int NG = (TABLE_DEPTH + GS - 1) / GS;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;

   logic [VALUE_W-1:0] tbl_ff [TABLE_DEPTH];
   logic [VALUE_W-1:0] mem [TABLE_DEPTH];

   // table write, flop copy for compares and memory copy for reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_ff[wr_addr] <= wr_data;
         mem[wr_addr]    <= wr_data;
      end
   end

   // stage 1: compare sample against every entry
   logic                   s1_valid_ff;
   logic [TABLE_DEPTH:0]   s1_cmp_ff;
   logic [VALUE_W-1:0]     s1_smp_ff;
   logic                   s1_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < TABLE_DEPTH; j++) begin
            s1_cmp_ff[j] <= (in_sample >= tbl_ff[j]);
         end
         s1_cmp_ff[TABLE_DEPTH] <= 1'b0;
         s1_smp_ff <= in_sample;
         s1_eof_ff <= in_eof;
      end
   end

   // stage 2: match vector and first match within each group
   logic [NG*GS-1:0] match;
   logic [NG-1:0]    grp_any_in;
   logic [3:0]       grp_idx_in [NG];

   always_comb begin
      match = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         match[k] = (CNT_W'(k) < searched) &&
                    ((k == 0 && !s1_cmp_ff[0]) || (s1_cmp_ff[k] && !s1_cmp_ff[k+1]));
      end
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = |match[g*GS +: GS];
         grp_idx_in[g] = '0;
         for (int i = GS - 1; i >= 0; i--) begin
            if (match[g*GS + i]) grp_idx_in[g] = 4'(i);
         end
      end
   end

   logic               s2_valid_ff;
   logic [NG-1:0]      s2_any_ff;
   logic [3:0]         s2_idx_ff [NG];
   logic               s2_c0_ff;
   logic [VALUE_W-1:0] s2_smp_ff;
   logic               s2_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_any_ff <= grp_any_in;
         for (int g = 0; g < NG; g++) s2_idx_ff[g] <= grp_idx_in[g];
         s2_c0_ff  <= s1_cmp_ff[0];
         s2_smp_ff <= s1_smp_ff;
         s2_eof_ff <= s1_eof_ff;
      end
   end

   // stage 3: first group, segment number and breakpoint read
   logic [GW-1:0]    grp_sel;
   logic [CNT_W-1:0] seg_full;
   logic [AW-1:0]    rd_lo_addr;
   logic [AW-1:0]    rd_hi_addr;
   logic             found_in;

   always_comb begin
      grp_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (s2_any_ff[g]) grp_sel = GW'(g);
      end
      found_in   = |s2_any_ff;
      seg_full   = CNT_W'(grp_sel) * CNT_W'(GS) + CNT_W'(s2_idx_ff[grp_sel]);
      rd_lo_addr = AW'(seg_full);
      rd_hi_addr = AW'(seg_full + CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result.valid <= 1'b0;
      end else if (advance) begin
         result.valid <= s2_valid_ff;
      end
      if (advance) begin
         result.eof   <= s2_eof_ff;
         result.found <= found_in;
         result.below <= (seg_full == '0) && !s2_c0_ff;
         result.seg   <= SEG_W'(seg_full);
         result.smp   <= s2_smp_ff;
         result.lo    <= mem[rd_lo_addr];
         result.hi    <= mem[rd_hi_addr];
      end
   end

   assign busy = s1_valid_ff | s2_valid_ff | result.valid;

endmodule

// File: hdl/plti_div.sv
// ----------------------------------------------------------------------------
// plti_div
// Pipelined restoring divider, one quotient bit per stage, giving the
// Q.16 fraction of a numerator below its divisor.
// ----------------------------------------------------------------------------
module plti_div
   import plti_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [VALUE_W-1:0] num,
   input  logic [VALUE_W-1:0] den,
   input  side_type           side_in,
   output logic               busy,
   output logic [FRAC_W-1:0]  quot,
   output side_type           side_out
);

   logic [VALUE_W-1:0] rem_ff  [FRAC_W+1];
   logic [VALUE_W-1:0] den_ff  [FRAC_W+1];
   logic [FRAC_W-1:0]  quot_ff [FRAC_W+1];
   side_type           side_ff [FRAC_W+1];
   logic [FRAC_W:0]    valid;

   // stage 0 loads the operands, each later stage resolves one bit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= FRAC_W; s++) side_ff[s].valid <= 1'b0;
      end else if (advance) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         quot_ff[0] <= '0;
         side_ff[0] <= side_in;
         for (int s = 1; s <= FRAC_W; s++) begin
            logic [VALUE_W:0] trial;
            trial = {rem_ff[s-1], 1'b0};
            if (trial >= {1'b0, den_ff[s-1]}) begin
               rem_ff[s]  <= VALUE_W'(trial - {1'b0, den_ff[s-1]});
               quot_ff[s] <= {quot_ff[s-1][FRAC_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= VALUE_W'(trial);
               quot_ff[s] <= {quot_ff[s-1][FRAC_W-2:0], 1'b0};
            end
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int s = 0; s <= FRAC_W; s++) valid[s] = side_ff[s].valid;
   end

   assign busy     = |valid;
   assign quot     = quot_ff[FRAC_W];
   assign side_out = side_ff[FRAC_W];

endmodule
